// ===== rtl/core/rar_pkg.sv =====
// shared types and constants for the rational arithmetic reduce block
package rar_pkg;

  localparam int unsigned OperandWidthDef = 16;
  localparam int unsigned FieldWidth = 16;
  localparam int unsigned NumOutWidth = 33;
  localparam int unsigned DenOutWidth = 32;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_GCD_START,
    ST_GCD_WAIT,
    ST_NUM_START,
    ST_NUM_WAIT,
    ST_DEN_START,
    ST_DEN_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]                    action;
    logic signed [FieldWidth-1:0]  first_numerator;
    logic signed [FieldWidth-1:0]  first_denominator;
    logic signed [FieldWidth-1:0]  second_numerator;
    logic signed [FieldWidth-1:0]  second_denominator;
  } in_beat_t;

  typedef struct packed {
    logic signed [NumOutWidth-1:0] result_numerator;
    logic signed [DenOutWidth-1:0] result_denominator;
    logic                          zero_divisor_error;
  } out_beat_t;

endpackage

// ===== rtl/core/rar_divider.sv =====
// restoring unsigned divider, one quotient bit per cycle
module rar_divider import rar_pkg::*; #(
  parameter int unsigned Width = 2 * OperandWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quotient_o,
  output logic [Width-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width:0]   rem_q, rem_d;
  logic [Width-1:0] quo_q, quo_d;
  logic [Width-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [Width:0]   shifted;
  logic [Width:0]   diff;

  assign shifted = {rem_q[Width-1:0], quo_q[Width-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = CntW'(Width);
    end else if (cnt_q != '0) begin
      if (!diff[Width]) begin
        rem_d = diff;
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q[Width-1:0];

endmodule

// ===== rtl/core/rational_arith_reduce.sv =====
// top level: rational add/sub/mul/div with gcd reduction
// One beat at a time: in_ready_o is high only when idle. An item forms three
// cross products one after another, combines them, then uses one shared
// restoring divider run per Euclid step and two more for the final reductions.
// Both raw parts zero skips the divider and flags zero_divisor_error.
module rational_arith_reduce import rar_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned NW = 2 * W + 1;

  state_e state_q, state_d;

  logic [1:0]          act_q;
  logic signed [W-1:0] a_q, b_q, c_q, d_q;
  logic [1:0]          step_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q;
  logic signed [NW-1:0] num_q;
  logic signed [PW-1:0] den_q;
  logic [PW-1:0]       gp_q, gq_q;
  logic [PW-1:0]       qn_q, qd_q;
  logic                err_q;

  logic signed [W-1:0]  mx, my;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]        mag_num, mag_den;
  logic                 div_start, div_done;
  logic [PW-1:0]        div_dividend, div_divisor, div_quo, div_rem;
  logic signed [NW-1:0] num_sum;
  logic signed [NW-1:0] num_res;
  logic signed [PW-1:0] den_res;

  function automatic logic signed [W-1:0] take(input logic [FieldWidth-1:0] f);
    logic [31:0] z;
    z = 32'(f);
    return z[W-1:0];
  endfunction

  always_comb begin
    mx = a_q;
    my = d_q;
    case (step_q)
      2'd0: begin
        mx = a_q;
        my = (action_e'(act_q) == ACT_MUL) ? c_q : d_q;
      end
      2'd1: begin
        mx = c_q;
        my = b_q;
      end
      default: begin
        mx = b_q;
        my = (action_e'(act_q) == ACT_DIV) ? c_q : d_q;
      end
    endcase
  end

  assign prod = PW'(mx) * PW'(my);

  always_comb begin
    case (action_e'(act_q))
      ACT_ADD: num_sum = NW'(p1_q) + NW'(p2_q);
      ACT_SUB: num_sum = NW'(p1_q) - NW'(p2_q);
      default: num_sum = NW'(p1_q);
    endcase
  end

  assign mag_num = num_q[NW-1] ? PW'(-num_q) : PW'(num_q);
  assign mag_den = den_q[PW-1] ? PW'(-den_q) : PW'(den_q);

  rar_divider #(.Width(PW)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_MUL;
      ST_MUL:       if (step_q == 2'd2) state_d = ST_SUM;
      ST_SUM:       state_d = (num_sum == '0 && p3_q == '0) ? ST_OUT : ST_GCD_START;
      ST_GCD_START: state_d = (gq_q == '0) ? ST_NUM_START : ST_GCD_WAIT;
      ST_GCD_WAIT:  if (div_done) state_d = ST_GCD_START;
      ST_NUM_START: state_d = ST_NUM_WAIT;
      ST_NUM_WAIT:  if (div_done) state_d = ST_DEN_START;
      ST_DEN_START: state_d = ST_DEN_WAIT;
      ST_DEN_WAIT:  if (div_done) state_d = ST_OUT;
      ST_OUT:       if (out_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    out_valid_o  = (state_q == ST_OUT);
    div_start    = 1'b0;
    div_dividend = gp_q;
    div_divisor  = gq_q;
    case (state_q)
      ST_GCD_START: div_start = (gq_q != '0);
      ST_NUM_START: begin
        div_start    = 1'b1;
        div_dividend = mag_num;
        div_divisor  = gp_q;
      end
      ST_DEN_START: begin
        div_start    = 1'b1;
        div_dividend = mag_den;
        div_divisor  = gp_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MUL) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      act_q <= in_data_i.action;
      a_q   <= take(in_data_i.first_numerator);
      b_q   <= take(in_data_i.first_denominator);
      c_q   <= take(in_data_i.second_numerator);
      d_q   <= take(in_data_i.second_denominator);
    end
    if (state_q == ST_MUL) begin
      case (step_q)
        2'd0:    p1_q <= prod;
        2'd1:    p2_q <= prod;
        default: p3_q <= prod;
      endcase
    end
    if (state_q == ST_SUM) begin
      num_q <= num_sum;
      den_q <= p3_q;
      err_q <= (num_sum == '0 && p3_q == '0);
      gp_q  <= num_sum[NW-1] ? PW'(-num_sum) : PW'(num_sum);
      gq_q  <= p3_q[PW-1] ? PW'(-p3_q) : PW'(p3_q);
      qn_q  <= '0;
      qd_q  <= '0;
    end
    if (state_q == ST_GCD_WAIT && div_done) begin
      gp_q <= gq_q;
      gq_q <= div_rem;
    end
    if (state_q == ST_NUM_WAIT && div_done) begin
      qn_q <= div_quo;
    end
    if (state_q == ST_DEN_WAIT && div_done) begin
      qd_q <= div_quo;
    end
  end

  assign num_res = num_q[NW-1] ? -NW'(qn_q) : NW'(qn_q);
  assign den_res = den_q[PW-1] ? -qd_q : qd_q;

  logic [63:0] num_wide, den_wide;
  assign num_wide = {{(64 - NW){num_res[NW-1]}}, num_res};
  assign den_wide = {{(64 - PW){den_res[PW-1]}}, den_res};

  always_comb begin
    out_data_o.result_numerator   = num_wide[NumOutWidth-1:0];
    out_data_o.result_denominator = den_wide[DenOutWidth-1:0];
    out_data_o.zero_divisor_error = err_q;
  end

endmodule
